// ===== design/cpe_pkg.sv =====
// Shared types, constants and functions of the CashAddr payload encoder.
// Holds the microcode word layout, the control store, the polymod fold and
// the base32 charset. No dependencies.
`default_nettype none

package cpe_pkg;

	localparam int POLY_W = 40;
	localparam int SYM_W  = 5;
	localparam int ACC_W  = 16;
	localparam int CNT_W  = 5;
	localparam int LOOP_W = 4;
	localparam int PC_W   = 3;

	localparam logic [LOOP_W-1:0] LOOP_LEN = 4'd8;

	localparam logic [POLY_W-1:0] GEN_TAB [5] = '{
		40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
		40'hae2eabe2a8, 40'h1e4f43e470
	};

	// ASCII codes of "qpzry9x8gf2tvdw0s3jn54khce6mua7l".
	localparam logic [6:0] CHARSET [32] = '{
		7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
		7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
		7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
		7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
	};

	// Version byte pieces.
	localparam logic [1:0] ATYPE_SCRIPT   = 2'd1;
	localparam logic [1:0] ATYPE_EXT      = 2'd2;
	localparam logic [7:0] VER_SCRIPT     = 8'h08;
	localparam logic [7:0] VER_EXT        = 8'h28;
	localparam logic [7:0] VER_SIZE_32    = 8'h03;

	// Configuration register indexes.
	localparam logic [1:0] REG_PREFIX_STATE = 2'd0;
	localparam logic [1:0] REG_ADDR_TYPE    = 2'd1;
	localparam logic [1:0] REG_HASH_32      = 2'd2;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_FETCH = 3'd0;
	localparam pc_t PC_DATA  = 3'd1;
	localparam pc_t PC_END   = 3'd2;
	localparam pc_t PC_PAD   = 3'd3;
	localparam pc_t PC_ZERO  = 3'd4;
	localparam pc_t PC_PREP  = 3'd5;
	localparam pc_t PC_CHK   = 3'd6;

	typedef enum logic [2:0] {
		C_ALWAYS = 3'd0,
		C_IN     = 3'd1,
		C_SYM    = 3'd2,
		C_LAST   = 3'd3,
		C_LEFT   = 3'd4,
		C_LOOP   = 3'd5
	} cond_t;

	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_CHK  = 2'd3
	} sym_src_t;

	typedef enum logic [2:0] {
		PO_HOLD  = 3'd0,
		PO_START = 3'd1,
		PO_LOAD  = 3'd2,
		PO_FOLD  = 3'd3,
		PO_XOR1  = 3'd4,
		PO_SHIFT = 3'd5
	} pop_t;

	typedef enum logic [1:0] {
		LP_HOLD = 2'd0,
		LP_LOAD = 2'd1,
		LP_DEC  = 2'd2
	} lop_t;

	// All actions of a word take effect only when its condition is true.
	typedef struct packed {
		cond_t    cond;
		logic     ld_in;
		logic     emit;
		sym_src_t src;
		pop_t     pop;
		lop_t     lop;
		logic     end_addr;
		pc_t      jt;
		pc_t      jf;
	} uword_t;

	typedef struct packed {
		pop_t             pop;
		logic [SYM_W-1:0] sym;
	} poly_ctl_t;

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = '{cond: C_ALWAYS, ld_in: 1'b0, emit: 1'b0, src: SRC_ZERO, pop: PO_HOLD,
			lop: LP_HOLD, end_addr: 1'b0, jt: PC_FETCH, jf: PC_FETCH};
		unique case (pc)
			PC_FETCH: begin
				w.cond = C_IN; w.ld_in = 1'b1; w.pop = PO_START;
				w.jt = PC_DATA; w.jf = PC_FETCH;
			end
			PC_DATA: begin
				w.cond = C_SYM; w.emit = 1'b1; w.src = SRC_DATA; w.pop = PO_FOLD;
				w.jt = PC_DATA; w.jf = PC_END;
			end
			PC_END: begin
				w.cond = C_LAST; w.lop = LP_LOAD;
				w.jt = PC_PAD; w.jf = PC_FETCH;
			end
			PC_PAD: begin
				w.cond = C_LEFT; w.emit = 1'b1; w.src = SRC_PAD; w.pop = PO_FOLD;
				w.jt = PC_ZERO; w.jf = PC_ZERO;
			end
			PC_ZERO: begin
				w.cond = C_LOOP; w.src = SRC_ZERO; w.pop = PO_FOLD; w.lop = LP_DEC;
				w.jt = PC_ZERO; w.jf = PC_PREP;
			end
			PC_PREP: begin
				w.cond = C_ALWAYS; w.pop = PO_XOR1; w.lop = LP_LOAD; w.end_addr = 1'b1;
				w.jt = PC_CHK; w.jf = PC_CHK;
			end
			PC_CHK: begin
				w.cond = C_LOOP; w.emit = 1'b1; w.src = SRC_CHK; w.pop = PO_SHIFT;
				w.lop = LP_DEC; w.jt = PC_CHK; w.jf = PC_FETCH;
			end
			default: begin
				w.jt = PC_FETCH; w.jf = PC_FETCH;
			end
		endcase
		return w;
	endfunction

	function automatic logic [POLY_W-1:0] poly_fold(input logic [POLY_W-1:0] st,
			input logic [SYM_W-1:0] sym);
		logic [POLY_W-1:0] c;
		c = {st[34:0], sym};
		for (int j = 0; j < 5; j++) begin
			if (st[35 + j])
				c = c ^ GEN_TAB[j];
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/cpe_polymod.sv =====
// The 40-bit BCH polymod register of the CashAddr encoder and its operations.
// Uses cpe_pkg for the operation codes and the fold function.
`default_nettype none

module cpe_polymod import cpe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire poly_ctl_t         ctl,
	input  wire logic [POLY_W-1:0] start_state,
	output logic      [POLY_W-1:0] state
);

	logic [POLY_W-1:0] poly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= {{(POLY_W-1){1'b0}}, 1'b1};
		end else begin
			unique case (ctl.pop)
				PO_HOLD:  poly_q <= poly_q;
				// The start load is resolved to a plain load or a hold by the sequencer.
				PO_START: poly_q <= poly_q;
				PO_LOAD:  poly_q <= start_state;
				PO_FOLD:  poly_q <= poly_fold(poly_q, ctl.sym);
				PO_XOR1:  poly_q <= poly_q ^ {{(POLY_W-1){1'b0}}, 1'b1};
				PO_SHIFT: poly_q <= {poly_q[POLY_W-SYM_W-1:0], {SYM_W{1'b0}}};
				default:  poly_q <= poly_q;
			endcase
		end
	end

	assign state = poly_q;

endmodule

`default_nettype wire

// ===== design/cashaddr_payload_encoder_unit.sv =====
// Top level of the CashAddr payload encoder: microcode sequencer, bit repacker
// and output register. Depends on cpe_pkg and cpe_polymod.
`default_nettype none

// Hash bytes enter one beat at a time and leave as base32 characters. Every
// step of the work is one word of a small control store, one word per clock
// unless an emitting step waits on the output: an ordinary byte passes the
// fetch step, one step per symbol it completes (one or two, three on the first
// byte of an address) and two steps of branch tests. The byte marked last
// additionally takes one padding step, eight zero-symbol polymod rounds plus
// their exit test, one preparation step and eight checksum characters plus
// their exit test. Any cycle that emits a character waits while the output
// beat is stalled. Only one byte is in work at a time; input stall is high
// except in the fetch step. The first byte of an address also carries the
// version byte, and a last mark on it is ignored. Configuration is sampled on
// the first byte of each address.

module cashaddr_payload_encoder_unit import cpe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [POLY_W-1:0]  cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         hash_byte,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [6:0]         char_code,
	output logic      [SYM_W-1:0]   symbol_value,
	output logic                    is_checksum,
	output logic                    last_char
);

	logic [POLY_W-1:0] prefix_state_q;
	logic [1:0]        addr_type_q;
	logic              hash32_q;

	pc_t               pc_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LOOP_W-1:0] loop_q;
	logic              at_start_q;
	logic              last_q;

	logic              out_valid_q;
	logic [6:0]        char_q;
	logic [SYM_W-1:0]  sym_q;
	logic              chk_q;
	logic              lastc_q;

	uword_t            uw;
	logic              cond_true;
	logic              adv;
	logic              act;
	logic [SYM_W-1:0]  sym;
	logic [SYM_W-1:0]  data_sym;
	logic [SYM_W-1:0]  pad_sym;
	logic [CNT_W-1:0]  data_sh;
	logic [2:0]        pad_sh;
	logic [7:0]        version;
	logic [POLY_W-1:0] poly;
	poly_ctl_t         pctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_state_q <= {{(POLY_W-1){1'b0}}, 1'b1};
			addr_type_q    <= 2'd0;
			hash32_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PREFIX_STATE: prefix_state_q <= cfg_data;
				REG_ADDR_TYPE:    addr_type_q    <= cfg_data[1:0];
				REG_HASH_32:      hash32_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign uw = ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS: cond_true = 1'b1;
			C_IN:     cond_true = in_valid;
			C_SYM:    cond_true = (cnt_q >= CNT_W'(SYM_W));
			C_LAST:   cond_true = last_q;
			C_LEFT:   cond_true = (cnt_q != '0);
			C_LOOP:   cond_true = (loop_q != '0);
			default:  cond_true = 1'b0;
		endcase
	end

	// A step that emits waits while the output register is full and stalled.
	assign adv = !(cond_true && uw.emit && out_valid_q && out_stall);
	assign act = cond_true && adv;

	assign data_sh  = cnt_q - CNT_W'(SYM_W);
	assign data_sym = SYM_W'(acc_q >> data_sh);
	assign pad_sh   = 3'(SYM_W) - cnt_q[2:0];
	assign pad_sym  = SYM_W'({1'b0, acc_q[3:0]} << pad_sh);

	always_comb begin
		unique case (uw.src)
			SRC_DATA: sym = data_sym;
			SRC_PAD:  sym = pad_sym;
			SRC_ZERO: sym = '0;
			SRC_CHK:  sym = poly[POLY_W-1 -: SYM_W];
			default:  sym = '0;
		endcase
	end

	always_comb begin
		if (addr_type_q == ATYPE_SCRIPT)
			version = VER_SCRIPT;
		else if (addr_type_q == ATYPE_EXT)
			version = VER_EXT;
		else
			version = 8'h00;
		if (hash32_q)
			version = version | VER_SIZE_32;
	end

	always_comb begin
		pctl.sym = sym;
		pctl.pop = PO_HOLD;
		if (act) begin
			if (uw.pop == PO_START)
				pctl.pop = at_start_q ? PO_LOAD : PO_HOLD;
			else
				pctl.pop = uw.pop;
		end
	end

	cpe_polymod u_polymod (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (pctl),
		.start_state (prefix_state_q),
		.state       (poly)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= PC_FETCH;
			cnt_q      <= '0;
			loop_q     <= '0;
			at_start_q <= 1'b1;
			last_q     <= 1'b0;
		end else if (adv) begin
			pc_q <= cond_true ? uw.jt : uw.jf;
			if (cond_true) begin
				if (uw.ld_in) begin
					// A last mark on the first byte of an address is ignored.
					last_q     <= last_byte && !at_start_q;
					at_start_q <= 1'b0;
					cnt_q      <= at_start_q ? CNT_W'(ACC_W) : cnt_q + CNT_W'(8);
				end
				if (uw.emit && uw.src == SRC_DATA)
					cnt_q <= data_sh;
				if (uw.emit && uw.src == SRC_PAD)
					cnt_q <= '0;
				unique case (uw.lop)
					LP_HOLD: loop_q <= loop_q;
					LP_LOAD: loop_q <= LOOP_LEN;
					LP_DEC:  loop_q <= loop_q - LOOP_W'(1);
					default: loop_q <= loop_q;
				endcase
				if (uw.end_addr) begin
					cnt_q      <= '0;
					at_start_q <= 1'b1;
					last_q     <= 1'b0;
				end
			end
		end
	end

	// Bit accumulator; only the low cnt_q bits are live.
	always_ff @(posedge clk) begin
		if (act && uw.ld_in)
			acc_q <= at_start_q ? {version, hash_byte} : {acc_q[7:0], hash_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (act && uw.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act && uw.emit) begin
			char_q  <= CHARSET[sym];
			sym_q   <= sym;
			chk_q   <= (uw.src == SRC_CHK);
			lastc_q <= (uw.src == SRC_CHK) && (loop_q == LOOP_W'(1));
		end
	end

	assign in_stall     = (pc_q != PC_FETCH);
	assign out_valid    = out_valid_q;
	assign char_code    = char_q;
	assign symbol_value = sym_q;
	assign is_checksum  = chk_q;
	assign last_char    = lastc_q;

	a_last_is_chk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |-> is_checksum)
		else $error("last character outside the checksum");

	a_char_map: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_code == CHARSET[symbol_value])
		else $error("character does not match its symbol");

	a_loop_range: assert property (@(posedge clk) disable iff (!arst_n)
		loop_q <= LOOP_LEN)
		else $error("round counter out of range");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ACC_W))
		else $error("bit count out of range");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for cashaddr_payload_encoder_unit.
// A built-in predictor of the version byte, 5-bit repacking, BCH polymod and
// checksum tracks every accepted hash byte. Depends on cpe_pkg and the RTL.

module tb_top;
	import cpe_pkg::*;

	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_BEATS  = 43;
	localparam int NUM_PHASES   = 8;

	localparam logic [1:0] ATYPE_KEY    = 2'd0;
	localparam logic [1:0] ATYPE_UNUSED = 2'd3;

	localparam logic [39:0] BCH_GEN [5] = '{
		40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
		40'hae2eabe2a8, 40'h1e4f43e470
	};
	localparam logic [8*32-1:0] B32_ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} hash_beat_t;

	typedef struct {
		logic [6:0] code;
		logic [4:0] sym;
		logic       chk;
		logic       fin;
	} char_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [POLY_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        hash_byte = '0;
	logic              last_byte = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [6:0]        char_code;
	logic [SYM_W-1:0]  symbol_value;
	logic              is_checksum;
	logic              last_char;

	cashaddr_payload_encoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hash_byte(hash_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code),
		.symbol_value(symbol_value),
		.is_checksum(is_checksum),
		.last_char(last_char)
	);

	always #6 clk = ~clk;

	hash_beat_t bytes_to_send [$];
	char_beat_t chars_due [$];
	hash_beat_t next_beat;
	char_beat_t want;
	int         error_count = 0;
	int         send_gap = 0;
	int         stall_left = 0;
	logic       idle_on = 1'b1;
	logic       long_armed = 1'b0;
	logic       long_used = 1'b0;

	// Mirror of the configuration registers and of the encoder state.
	logic [39:0] prefix_cfg = 40'd1;
	logic [1:0]  atype_cfg = ATYPE_KEY;
	logic        size32_cfg = 1'b0;
	logic [39:0] poly_state = 40'd1;
	logic [3:0]  spare_bits = '0;
	logic [2:0]  spare_cnt = '0;
	logic        addr_fresh = 1'b1;

	task automatic flag_error(input string msg);
		error_count++;
		$display("%0t: %s", $time, msg);
	endtask

	function automatic logic [39:0] bch_fold(input logic [39:0] st, input logic [4:0] s);
		logic [39:0] c;
		logic [4:0]  top;
		top = st[39:35];
		c = {st[34:0], s};
		for (int j = 0; j < 5; j++)
			if (top[j])
				c = c ^ BCH_GEN[j];
		return c;
	endfunction

	task automatic push_char(input logic [4:0] s, input logic chk, input logic fin);
		char_beat_t c;
		c.code = B32_ALPHABET[8*(31-s) +: 7];
		c.sym = s;
		c.chk = chk;
		c.fin = fin;
		chars_due = {chars_due, c};
	endtask

	// Appends eight bits to the leftover bits and emits every full symbol.
	task automatic repack(input logic [7:0] value);
		logic [11:0] acc;
		logic [4:0]  s;
		int          nb;
		acc = {spare_bits, value};
		nb = spare_cnt + 8;
		while (nb >= 5) begin
			nb -= 5;
			s = 5'(acc >> nb);
			poly_state = bch_fold(poly_state, s);
			push_char(s, 1'b0, 1'b0);
		end
		spare_bits = 4'(acc & ((12'd1 << nb) - 12'd1));
		spare_cnt = 3'(nb);
	endtask

	task automatic encode_byte(input logic [7:0] data, input logic fin);
		logic [7:0]  version;
		logic [39:0] chk;
		logic [4:0]  pad;
		if (addr_fresh) begin
			// The first byte carries the version byte; its last mark does not count.
			case (atype_cfg)
				ATYPE_SCRIPT: version = VER_SCRIPT;
				ATYPE_EXT:    version = VER_EXT;
				default:      version = '0;
			endcase
			if (size32_cfg)
				version = version | VER_SIZE_32;
			poly_state = prefix_cfg;
			spare_bits = '0;
			spare_cnt = '0;
			addr_fresh = 1'b0;
			repack(version);
			repack(data);
		end else begin
			repack(data);
			if (fin) begin
				if (spare_cnt != 0) begin
					pad = 5'({1'b0, spare_bits} << (5 - spare_cnt));
					poly_state = bch_fold(poly_state, pad);
					push_char(pad, 1'b0, 1'b0);
				end
				repeat (8) poly_state = bch_fold(poly_state, 5'd0);
				chk = poly_state ^ 40'd1;
				for (int i = 7; i >= 0; i--)
					push_char(chk[5*i +: 5], 1'b1, i == 0);
				spare_bits = '0;
				spare_cnt = '0;
				addr_fresh = 1'b1;
			end
		end
	endtask

	// Sender: one beat held until accepted, with random bursts of idle cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				encode_byte(hash_byte, last_byte);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (idle_on && bytes_to_send.size() != 0 &&
						$urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else if (bytes_to_send.size() != 0) begin
					next_beat = bytes_to_send.pop_front();
					in_valid <= 1'b1;
					hash_byte <= next_beat.data;
					last_byte <= next_beat.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted character, stalls in random bursts and, once armed, in one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			long_used <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (chars_due.size() == 0) begin
					flag_error($sformatf("character %h arrived with none expected", char_code));
				end else begin
					want = chars_due.pop_front();
					if (char_code !== want.code)
						flag_error($sformatf("char_code %h, expected %h", char_code, want.code));
					if (symbol_value !== want.sym)
						flag_error($sformatf("symbol_value %h, expected %h",
							symbol_value, want.sym));
					if (is_checksum !== want.chk)
						flag_error($sformatf("is_checksum %b, expected %b", is_checksum, want.chk));
					if (last_char !== want.fin)
						flag_error($sformatf("last_char %b, expected %b", last_char, want.fin));
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (long_armed && !long_used) begin
				long_used <= 1'b1;
				stall_left <= LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				stall_left <= $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PREFIX_STATE: prefix_cfg = val;
			REG_ADDR_TYPE:    atype_cfg = val[1:0];
			REG_HASH_32:      size32_cfg = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_beat(input logic [7:0] data, input logic fin);
		hash_beat_t b;
		b.data = data;
		b.fin = fin;
		bytes_to_send = {bytes_to_send, b};
	endtask

	task automatic queue_address(input int len);
		logic [7:0] data;
		logic       fin;
		for (int i = 0; i < len; i++) begin
			data = 8'($urandom_range(0, 255));
			if (i == len - 1)
				fin = 1'b1;
			else if (i == 0)
				fin = 1'($urandom_range(0, 1));
			else
				fin = 1'b0;
			queue_beat(data, fin);
		end
	endtask

	task automatic queue_random_addresses(input int beats);
		int total;
		int pick;
		total = 0;
		while (total < beats) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				queue_address(32);
				total += 32;
			end else if (pick == 1) begin
				queue_address(20);
				total += 20;
			end else begin
				pick = $urandom_range(2, 10);
				queue_address(pick);
				total += pick;
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (bytes_to_send.size() != 0 || in_valid || chars_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [39:0] rand40();
		return {8'($urandom()), 32'($urandom())};
	endfunction

	initial begin
		logic [39:0] val;
		logic [1:0]  atype;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed addresses under the reset configuration, lengths two to six,
		// so the final leftover count runs through every value.
		queue_beat(8'h00, 1'b1);
		queue_beat(8'hff, 1'b1);
		queue_beat(8'hff, 1'b0);
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h80, 1'b1);
		queue_beat(8'h01, 1'b1);
		queue_beat(8'h7f, 1'b0);
		queue_beat(8'haa, 1'b0);
		queue_beat(8'h55, 1'b1);
		queue_beat(8'hfe, 1'b0);
		queue_beat(8'hef, 1'b0);
		queue_beat(8'h10, 1'b0);
		queue_beat(8'h20, 1'b0);
		queue_beat(8'h00, 1'b1);
		queue_beat(8'hff, 1'b1);
		queue_beat(8'hff, 1'b0);
		queue_beat(8'hff, 1'b0);
		queue_beat(8'hff, 1'b0);
		queue_beat(8'hff, 1'b0);
		queue_beat(8'hff, 1'b1);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin val = '0;       atype = ATYPE_KEY; end
				1: begin val = '1;       atype = ATYPE_UNUSED; end
				2: begin val = rand40(); atype = ATYPE_SCRIPT; end
				3: begin val = rand40(); atype = ATYPE_EXT; end
				default: begin val = rand40(); atype = 2'($urandom_range(0, 3)); end
			endcase
			write_reg(REG_PREFIX_STATE, val);
			// Upper data bits are noise for the narrow registers.
			val = rand40();
			val[1:0] = atype;
			write_reg(REG_ADDR_TYPE, val);
			val = rand40();
			val[0] = (p == 1 || p == 3) ? 1'b1 : (p == 0 || p == 2) ? 1'b0 : val[0];
			write_reg(REG_HASH_32, val);

			@(negedge clk);
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;
			queue_random_addresses(PHASE_BEATS);
			// Receiver holds off for a long stretch while beats keep coming.
			if (p == 2)
				long_armed = 1'b1;
			wait_drained();
		end

		if (error_count == 0)
			$display("[cashaddr_payload_encoder_unit] OK");
		else
			$display("[cashaddr_payload_encoder_unit] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[cashaddr_payload_encoder_unit] ERROR");
		$finish;
	end

endmodule

// ===== cashaddr_payload_encoder_unit.f =====
design/cpe_pkg.sv
design/cpe_polymod.sv
design/cashaddr_payload_encoder_unit.sv
test/tb_top.sv
